### hw/rtl/dq_pkg.sv
// shared types and constants for the double-ended queue
package dq_pkg;

    localparam int DATA_W   = 32;
    localparam int FILL_W   = 5;
    localparam int DQ_DEPTH = 16;

    localparam logic [DATA_W-1:0] EMPTY_DATA = '1;

    typedef enum logic [2:0] {
        CMD_PUSH_FRONT = 3'd0,
        CMD_PUSH_REAR  = 3'd1,
        CMD_POP_FRONT  = 3'd2,
        CMD_POP_REAR   = 3'd3,
        CMD_PEEK_FRONT = 3'd4,
        CMD_PEEK_REAR  = 3'd5
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_UNDERFLOW = 2'd1,
        ST_OVERFLOW  = 2'd2
    } t_status;

    // outcome of one command as seen by the sequencer
    typedef struct packed {
        logic    rd;
        t_status status;
    } t_op;

endpackage

### hw/rtl/dq_ram.sv
// generic single-clock ram with one write port and one registered read port
module dq_ram #(
    parameter int WIDTH  = 32,
    parameter int DEPTH  = 16,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

### hw/rtl/dq_ring.sv
// head and count tracking of the ring buffer, with ram address generation
module dq_ring
    import dq_pkg::*;
#(
    parameter int DEPTH  = DQ_DEPTH,
    localparam int ADDR_W = $clog2(DEPTH),
    localparam int CNT_W  = $clog2(DEPTH + 1)
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_go,
    input  logic [2:0]        i_cmd,
    output logic              o_we,
    output logic [ADDR_W-1:0] o_waddr,
    output logic              o_re,
    output logic [ADDR_W-1:0] o_raddr,
    output t_op               o_op,
    output logic [FILL_W-1:0] o_fill
);

    localparam logic [ADDR_W:0]   DEPTH_X  = (ADDR_W + 1)'(DEPTH);
    localparam logic [ADDR_W-1:0] LAST_IDX = ADDR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0]  FULL_CNT = CNT_W'(DEPTH);

    logic [ADDR_W-1:0] r_head;
    logic [CNT_W-1:0]  r_count;
    logic [ADDR_W-1:0] n_head;
    logic [CNT_W-1:0]  n_count;

    logic              full;
    logic              empty;
    logic [ADDR_W-1:0] head_dec;
    logic [ADDR_W-1:0] head_inc;
    logic [ADDR_W:0]   tail_sum;
    logic [ADDR_W:0]   last_sum;
    logic [ADDR_W-1:0] tail_idx;
    logic [ADDR_W-1:0] last_idx;
    logic              we;

    assign full     = (r_count == FULL_CNT);
    assign empty    = (r_count == '0);
    assign head_dec = (r_head == '0) ? LAST_IDX : r_head - ADDR_W'(1);
    assign head_inc = (r_head == LAST_IDX) ? '0 : r_head + ADDR_W'(1);

    // slot after the last element and slot of the last element, wrapped once
    assign tail_sum = {1'b0, r_head} + (ADDR_W + 1)'(r_count);
    assign last_sum = {1'b0, r_head} + (ADDR_W + 1)'(r_count - CNT_W'(1));
    assign tail_idx = (tail_sum >= DEPTH_X) ? ADDR_W'(tail_sum - DEPTH_X) : ADDR_W'(tail_sum);
    assign last_idx = (last_sum >= DEPTH_X) ? ADDR_W'(last_sum - DEPTH_X) : ADDR_W'(last_sum);

    always_comb begin
        we          = 1'b0;
        o_op.rd     = 1'b0;
        o_op.status = ST_OK;
        o_waddr     = r_head;
        o_raddr     = r_head;
        n_head      = r_head;
        n_count     = r_count;
        unique case (t_cmd'(i_cmd))
            CMD_PUSH_FRONT: begin
                if (full) begin
                    o_op.status = ST_OVERFLOW;
                end else begin
                    we      = 1'b1;
                    o_waddr = head_dec;
                    n_head  = head_dec;
                    n_count = r_count + CNT_W'(1);
                end
            end
            CMD_PUSH_REAR: begin
                if (full) begin
                    o_op.status = ST_OVERFLOW;
                end else begin
                    we      = 1'b1;
                    o_waddr = tail_idx;
                    n_count = r_count + CNT_W'(1);
                end
            end
            CMD_POP_FRONT, CMD_PEEK_FRONT: begin
                if (empty) begin
                    o_op.status = ST_UNDERFLOW;
                end else begin
                    o_op.rd = 1'b1;
                    o_raddr = r_head;
                    if (t_cmd'(i_cmd) == CMD_POP_FRONT) begin
                        n_head  = head_inc;
                        n_count = r_count - CNT_W'(1);
                    end
                end
            end
            CMD_POP_REAR, CMD_PEEK_REAR: begin
                if (empty) begin
                    o_op.status = ST_UNDERFLOW;
                end else begin
                    o_op.rd = 1'b1;
                    o_raddr = last_idx;
                    if (t_cmd'(i_cmd) == CMD_POP_REAR) begin
                        n_count = r_count - CNT_W'(1);
                    end
                end
            end
            default: begin
            end
        endcase
    end

    assign o_we   = i_go && we;
    assign o_re   = i_go && o_op.rd;
    assign o_fill = FILL_W'(n_count);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_count <= '0;
        end else if (i_go) begin
            r_head  <= n_head;
            r_count <= n_count;
        end
    end

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FULL_CNT)
        else $error("element count beyond depth");

    a_head_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_head <= LAST_IDX)
        else $error("head index beyond depth");

    a_pop_front: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_go && t_cmd'(i_cmd) == CMD_POP_FRONT && !empty
        |=> r_count == $past(r_count) - CNT_W'(1) && r_head == $past(head_inc))
        else $error("pop front did not advance head and count");

endmodule

### hw/rtl/double_ended_queue.sv
// bounded double-ended queue of signed 32-bit values on a ring-buffer ram
//
// input channel: i_valid / o_ready carry one command (i_cmd) and, for pushes,
// the element (i_value). output channel: o_valid / i_ready return one result
// per command: o_data, o_status and o_fill_count (elements held afterwards).
// a transfer happens on a rising edge with valid and ready both high.
//
// pushes, rejected commands and unknown commands give their result in the
// output register in the cycle after the input transfer; pops and peeks on a
// non-empty queue read the registered ram port, then pass the read state,
// and their result is registered after it. pushes sustain one command per
// cycle while results are taken; a read holds off new commands meanwhile.
//
// reset (i_rst_n low on a clock edge) empties the queue and drops any pending
// result; ram contents stay as they were and are never read before a push.
// while a result waits on a stalled receiver, no new command is taken, except
// in the cycle in which the waiting result is transferred.
module double_ended_queue
    import dq_pkg::*;
#(
    parameter int DEPTH = DQ_DEPTH
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_ready,
    input  logic [2:0]               i_cmd,
    input  logic signed [DATA_W-1:0] i_value,
    output logic                     o_valid,
    input  logic                     i_ready,
    output logic signed [DATA_W-1:0] o_data,
    output logic [1:0]               o_status,
    output logic [FILL_W-1:0]        o_fill_count
);

    localparam int ADDR_W = $clog2(DEPTH);

    typedef enum logic {
        S_IDLE,
        S_READ
    } t_state;

    t_state                   r_state;
    logic                     r_out_valid;
    logic [DATA_W-1:0]        r_data;
    t_status                  r_status;
    logic [FILL_W-1:0]        r_fill;

    logic                     in_xfer;
    logic                     ram_we;
    logic                     ram_re;
    logic [ADDR_W-1:0]        ram_waddr;
    logic [ADDR_W-1:0]        ram_raddr;
    logic [DATA_W-1:0]        ram_rdata;
    t_op                      op;
    logic [FILL_W-1:0]        fill;

    assign o_ready = (r_state == S_IDLE) && (!r_out_valid || i_ready);
    assign in_xfer = i_valid && o_ready;

    dq_ring #(
        .DEPTH (DEPTH)
    ) u_ring (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_go    (in_xfer),
        .i_cmd   (i_cmd),
        .o_we    (ram_we),
        .o_waddr (ram_waddr),
        .o_re    (ram_re),
        .o_raddr (ram_raddr),
        .o_op    (op),
        .o_fill  (fill)
    );

    dq_ram #(
        .WIDTH (DATA_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (i_value),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (in_xfer) begin
                        r_status <= op.status;
                        r_fill   <= fill;
                        if (op.rd) begin
                            // result waits for the ram read
                            r_state     <= S_READ;
                            r_out_valid <= 1'b0;
                        end else begin
                            r_out_valid <= 1'b1;
                            r_data      <= (op.status == ST_UNDERFLOW) ? EMPTY_DATA : '0;
                        end
                    end else if (r_out_valid && i_ready) begin
                        r_out_valid <= 1'b0;
                    end
                end
                S_READ: begin
                    r_state     <= S_IDLE;
                    r_out_valid <= 1'b1;
                    r_data      <= ram_rdata;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_valid      = r_out_valid;
    assign o_data       = r_data;
    assign o_status     = r_status;
    assign o_fill_count = r_fill;

    a_read_slot_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_READ |-> !r_out_valid)
        else $error("output register busy while a ram read is in flight");

    a_read_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer && op.rd |=> r_state == S_READ)
        else $error("ram read transfer did not enter the read state");

    a_read_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_READ |=> o_valid && o_status == ST_OK)
        else $error("ram read did not produce a result");

    a_empty_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status == ST_UNDERFLOW |-> o_data == EMPTY_DATA)
        else $error("underflow result without the empty marker");

endmodule
